### hw/rtl/rskq_pkg.sv
// Shared types and constants for the rotary speed key queue.
`timescale 1ns / 1ps

package rskq_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned KEY_W   = 3;
    localparam int unsigned QCNT_W  = 4;

    // Bit positions inside the result tdata word.
    localparam int unsigned OUT_KEY_LSB  = 0;
    localparam int unsigned OUT_QCNT_LSB = KEY_W;
    localparam int unsigned OUT_TDATA_W  = 8;
    localparam int unsigned IN_TDATA_W   = 8;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic [LIMIT_W-1:0] FAST_LIMIT_RST   = 16'd20;
    localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 16'd100;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_BUTTON = 2'd1,
        ACT_DETENT = 2'd2,
        ACT_POP    = 2'd3
    } t_action;

    typedef enum logic {
        CFG_FAST_LIMIT   = 1'b0,
        CFG_MEDIUM_LIMIT = 1'b1
    } t_cfg_index;

    typedef logic [KEY_W-1:0] t_key;

    localparam t_key KEY_NONE  = 3'd0;
    localparam t_key KEY_PRESS = 3'd1;
    localparam t_key KEY_FWD   = 3'd2;
    localparam t_key KEY_FWD2  = 3'd3;
    localparam t_key KEY_FWD10 = 3'd4;
    localparam t_key KEY_BWD   = 3'd5;
    localparam t_key KEY_BWD2  = 3'd6;
    localparam t_key KEY_BWD10 = 3'd7;

endpackage

### hw/rtl/rotary_speed_key_queue.sv
// Rotary encoder speed classifier with a key FIFO, top level.
// Each input item updates the elapsed tick counter or the key FIFO
// and loads exactly one result into the output register. An item is accepted every cycle while
// the output register is empty or being drained, so the block sustains one item per clock; a
// stall on the result side stops intake after one result waits. Ticks saturate at 65535. A
// detent queues forward or backward at step 10 when the elapsed count is below fast_limit, at
// step 2 when below medium_limit, else at step 1, and then clears the count. Keys arriving at a
// full FIFO are dropped, a pop on an empty FIFO returns none, and queue_count shows the low four
// bits of the number of keys held after the item.
`timescale 1ns / 1ps

module rotary_speed_key_queue #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes.
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_index,
    input  logic [rskq_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] action, [2] button_level, [3] direction_level, [7:4] zero
    input  logic [rskq_pkg::IN_TDATA_W-1:0]     s_tdata,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] popped_key, [6:3] queue_count, [7] zero
    output logic [rskq_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    logic [rskq_pkg::LIMIT_W-1:0] r_fast_limit;
    logic [rskq_pkg::LIMIT_W-1:0] r_medium_limit;
    logic [rskq_pkg::TICK_W-1:0]  r_elapsed;
    logic [rskq_pkg::TICK_W-1:0]  n_elapsed;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [IDX_W-1:0]             r_head;
    logic [IDX_W-1:0]             r_tail;
    rskq_pkg::t_key               r_store [QUEUE_DEPTH];
    logic                         r_out_valid;
    rskq_pkg::t_key               r_out_key;
    logic [rskq_pkg::QCNT_W-1:0]  r_out_qcnt;

    rskq_pkg::t_action            in_action;
    logic                         in_button;
    logic                         in_dir;
    logic                         accept;
    logic                         do_push;
    logic                         do_pop;
    rskq_pkg::t_key               push_key;

    assign in_action = rskq_pkg::t_action'(s_tdata[1:0]);
    assign in_button = s_tdata[2];
    assign in_dir    = s_tdata[3];

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        n_elapsed = r_elapsed;
        n_count   = r_count;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        push_key  = rskq_pkg::KEY_PRESS;
        case (in_action)
            rskq_pkg::ACT_TICK: begin
                if (r_elapsed != rskq_pkg::TICK_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end
            rskq_pkg::ACT_BUTTON: begin
                do_push = !in_button;
            end
            rskq_pkg::ACT_DETENT: begin
                // The fast test wins regardless of how the two limits relate.
                if (r_elapsed < r_fast_limit) begin
                    push_key = in_dir ? rskq_pkg::KEY_FWD10 : rskq_pkg::KEY_BWD10;
                end else if (r_elapsed < r_medium_limit) begin
                    push_key = in_dir ? rskq_pkg::KEY_FWD2 : rskq_pkg::KEY_BWD2;
                end else begin
                    push_key = in_dir ? rskq_pkg::KEY_FWD : rskq_pkg::KEY_BWD;
                end
                do_push   = 1'b1;
                n_elapsed = '0;
            end
            rskq_pkg::ACT_POP: begin
                if (r_count != '0) begin
                    do_pop = 1'b1;
                end
            end
            default: begin
                do_pop = 1'b0;
            end
        endcase
        // A key that finds the FIFO full is dropped.
        if (do_push && (r_count == CNT_FULL)) begin
            do_push = 1'b0;
        end
        if (do_push) begin
            n_count = r_count + 1'b1;
        end else if (do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_limit   <= rskq_pkg::FAST_LIMIT_RST;
            r_medium_limit <= rskq_pkg::MEDIUM_LIMIT_RST;
            r_elapsed      <= '0;
            r_count        <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (rskq_pkg::t_cfg_index'(i_cfg_index))
                    rskq_pkg::CFG_FAST_LIMIT:   r_fast_limit   <= i_cfg_wdata;
                    rskq_pkg::CFG_MEDIUM_LIMIT: r_medium_limit <= i_cfg_wdata;
                    default: begin
                        r_fast_limit <= r_fast_limit;
                    end
                endcase
            end
            if (accept) begin
                r_elapsed   <= n_elapsed;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                if (do_pop) begin
                    r_head <= (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
                end
                if (do_push) begin
                    r_tail <= (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
                end
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Key storage is a circular buffer; the head entry is read straight into the result register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_key  <= do_pop ? r_store[r_head] : rskq_pkg::KEY_NONE;
            r_out_qcnt <= rskq_pkg::QCNT_W'(n_count);
            if (do_push) begin
                r_store[r_tail] <= push_key;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out_qcnt, r_out_key};

endmodule

### hw/rtl/rskq_checker.sv
// Port-level checks for the rotary speed key queue, bound to the top level.
`timescale 1ns / 1ps

module rskq_checker #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [rskq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rskq_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [rskq_pkg::QCNT_W-1:0] out_qcnt;
    logic                        in_is_pop;

    assign out_qcnt  = m_tdata[rskq_pkg::OUT_QCNT_LSB +: rskq_pkg::QCNT_W];
    assign in_is_pop = (s_tdata[1:0] == rskq_pkg::ACT_POP);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every accepted item leaves a result in the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // Intake is open whenever no result is waiting.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Only a pop can report a key, and the count never passes the depth.
    a_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !in_is_pop |=>
            (m_tdata[rskq_pkg::OUT_KEY_LSB +: rskq_pkg::KEY_W] == rskq_pkg::KEY_NONE)
            && ((QUEUE_DEPTH > 15) || (int'(out_qcnt) <= QUEUE_DEPTH)))
        else $error("unexpected key or count");

endmodule

bind rotary_speed_key_queue rskq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_rskq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/rotary_speed_key_queue_tb.sv
// Self-checking testbench for the rotary speed key queue: directed table and random phases.
`timescale 1ns / 1ps

module rotary_speed_key_queue_tb;

    localparam int unsigned QUEUE_DEPTH  = 8;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned LIMIT_CYCLES = 800000;
    localparam int unsigned NUM_ROWS     = 27;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned PHASE_ITEMS  = 250;

    typedef struct packed {
        rskq_pkg::t_key              key;
        logic [rskq_pkg::QCNT_W-1:0] count;
    } t_key_result;

    // One row of the directed table: either a register write or an item.
    typedef struct packed {
        bit                           is_cfg;
        rskq_pkg::t_cfg_index         idx;
        logic [rskq_pkg::LIMIT_W-1:0] value;
        rskq_pkg::t_action            act;
        logic                         btn;
        logic                         dir;
        bit                           typed;
        rskq_pkg::t_key               key;
        logic [rskq_pkg::QCNT_W-1:0]  count;
    } t_stim_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic                             i_cfg_index;
    logic [rskq_pkg::LIMIT_W-1:0]     i_cfg_wdata;
    logic                             s_tvalid;
    logic                             s_tready;
    // [1:0] action, [2] button_level, [3] direction_level, [7:4] zero
    logic [rskq_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    // [2:0] popped_key, [6:3] queue_count, [7] zero
    logic [rskq_pkg::OUT_TDATA_W-1:0] m_tdata;

    // Shadow state of the block.
    logic [rskq_pkg::LIMIT_W-1:0] model_fast;
    logic [rskq_pkg::LIMIT_W-1:0] model_medium;
    logic [rskq_pkg::TICK_W-1:0]  model_elapsed;
    rskq_pkg::t_key               model_keys[$];

    t_key_result expected_results[$];
    t_stim_row   stim_rows [NUM_ROWS];
    int          fail_count;
    bit          no_gaps;
    bit          hold_results;

    rotary_speed_key_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_key(rskq_pkg::t_key code);
        if (model_keys.size() < QUEUE_DEPTH) begin
            model_keys.push_back(code);
        end
    endfunction

    // Applies one item to the shadow state and returns the result it causes.
    function automatic t_key_result step_key_model(rskq_pkg::t_action act, logic btn,
                                                   logic dir);
        t_key_result    res;
        rskq_pkg::t_key code;
        res.key = rskq_pkg::KEY_NONE;
        case (act)
            rskq_pkg::ACT_TICK: begin
                if (model_elapsed != rskq_pkg::TICK_MAX) model_elapsed++;
            end
            rskq_pkg::ACT_BUTTON: begin
                if (!btn) queue_key(rskq_pkg::KEY_PRESS);
            end
            rskq_pkg::ACT_DETENT: begin
                // The fast test wins even when the limits are out of order.
                if (model_elapsed < model_fast) begin
                    code = dir ? rskq_pkg::KEY_FWD10 : rskq_pkg::KEY_BWD10;
                end else if (model_elapsed < model_medium) begin
                    code = dir ? rskq_pkg::KEY_FWD2 : rskq_pkg::KEY_BWD2;
                end else begin
                    code = dir ? rskq_pkg::KEY_FWD : rskq_pkg::KEY_BWD;
                end
                queue_key(code);
                model_elapsed = '0;
            end
            default: begin
                if (model_keys.size() != 0) res.key = model_keys.pop_front();
            end
        endcase
        res.count = rskq_pkg::QCNT_W'(model_keys.size());
        return res;
    endfunction

    task automatic send_item(rskq_pkg::t_action act, logic btn, logic dir, bit typed,
                             t_key_result typed_res);
        int          gap;
        t_key_result predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, dir, btn, act};
        do @(posedge i_clk); while (!s_tready);
        predicted = step_key_model(act, btn, dir);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic send_random(rskq_pkg::t_action act);
        send_item(act, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(rskq_pkg::t_cfg_index idx, logic [rskq_pkg::LIMIT_W-1:0] value);
        wait_all_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == rskq_pkg::CFG_FAST_LIMIT) begin
            model_fast = value;
        end else begin
            model_medium = value;
        end
    endtask

    // Result side: random stalls per item, plus one long hold on request.
    initial begin : result_sink
        int gap;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_key_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: tdata %0h", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[rskq_pkg::OUT_KEY_LSB +: rskq_pkg::KEY_W] !== want.key) begin
                    $error("popped_key: expected %0d, actual %0d",
                           want.key, m_tdata[rskq_pkg::OUT_KEY_LSB +: rskq_pkg::KEY_W]);
                    fail_count++;
                end
                if (m_tdata[rskq_pkg::OUT_QCNT_LSB +: rskq_pkg::QCNT_W] !== want.count) begin
                    $error("queue_count: expected %0d, actual %0d",
                           want.count, m_tdata[rskq_pkg::OUT_QCNT_LSB +: rskq_pkg::QCNT_W]);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int                           p;
        int                           r;
        int                           sent;
        int                           run;
        int                           pop_share;
        logic [rskq_pkg::LIMIT_W-1:0] fast;
        logic [rskq_pkg::LIMIT_W-1:0] mid_lim;
        t_key_result                  typed_res;

        fail_count   = 0;
        no_gaps      = 1'b0;
        hold_results = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= 1'b0;
        i_cfg_wdata <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;

        model_fast    = rskq_pkg::FAST_LIMIT_RST;
        model_medium  = rskq_pkg::MEDIUM_LIMIT_RST;
        model_elapsed = '0;
        model_keys.delete();

        stim_rows = '{
            // Reset limits: empty pop, released and pressed button, fast detents.
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b0, 1'b0, 1'b1, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_BUTTON,
              1'b1, 1'b0, 1'b1, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_BUTTON,
              1'b0, 1'b1, 1'b1, rskq_pkg::KEY_NONE, 4'd1},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_DETENT,
              1'b0, 1'b1, 1'b1, rskq_pkg::KEY_NONE, 4'd2},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_DETENT,
              1'b1, 1'b0, 1'b1, rskq_pkg::KEY_NONE, 4'd3},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b1, 1'b1, 1'b1, rskq_pkg::KEY_PRESS, 4'd2},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b0, 1'b0, 1'b1, rskq_pkg::KEY_FWD10, 4'd1},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b0, 1'b0, 1'b1, rskq_pkg::KEY_BWD10, 4'd0},
            // Tight limits: medium and slow detents.
            '{1'b1, rskq_pkg::CFG_FAST_LIMIT, 16'd1, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b1, rskq_pkg::CFG_MEDIUM_LIMIT, 16'd3, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b1, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_DETENT,
              1'b0, 1'b1, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_TICK,
              1'b1, 1'b1, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_DETENT,
              1'b1, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            // Zero limits leave only the slow class.
            '{1'b1, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b1, rskq_pkg::CFG_MEDIUM_LIMIT, 16'd0, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_DETENT,
              1'b0, 1'b1, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            // Limits out of order: fast is tested first.
            '{1'b1, rskq_pkg::CFG_FAST_LIMIT, 16'hFFFF, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b1, rskq_pkg::CFG_MEDIUM_LIMIT, 16'd2, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_TICK,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_DETENT,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0},
            '{1'b0, rskq_pkg::CFG_FAST_LIMIT, 16'd0, rskq_pkg::ACT_POP,
              1'b0, 1'b0, 1'b0, rskq_pkg::KEY_NONE, 4'd0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_ROWS; r++) begin
            if (stim_rows[r].is_cfg) begin
                write_limit(stim_rows[r].idx, stim_rows[r].value);
            end else begin
                typed_res.key   = stim_rows[r].key;
                typed_res.count = stim_rows[r].count;
                send_item(stim_rows[r].act, stim_rows[r].btn, stim_rows[r].dir,
                          stim_rows[r].typed, typed_res);
            end
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       begin fast = 16'd1;    mid_lim = 16'd2;    end
                1:       begin fast = 16'd3;    mid_lim = 16'd8;    end
                2:       begin fast = 16'd0;    mid_lim = 16'd6;    end
                3:       begin fast = 16'hFFFF; mid_lim = 16'hFFFF; end
                4:       begin fast = 16'd8;    mid_lim = 16'd3;    end
                5:       begin fast = 16'd1;    mid_lim = 16'd1;    end
                default: begin
                    fast    = 16'($urandom_range(0, 10));
                    mid_lim = 16'($urandom_range(0, 20));
                end
            endcase
            write_limit(rskq_pkg::CFG_FAST_LIMIT, fast);
            write_limit(rskq_pkg::CFG_MEDIUM_LIMIT, mid_lim);
            // Odd phases lean toward pushes so the queue fills and drops keys.
            pop_share = (p % 2 == 1) ? 15 : 40;
            no_gaps   = (p == 6);
            // The sender keeps offering while the result side holds off.
            if (p == 2) hold_results = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < pop_share) begin
                    send_random(rskq_pkg::ACT_POP);
                    sent++;
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            run = $urandom_range(1, 12);
                            repeat (run) send_random(rskq_pkg::ACT_TICK);
                            sent += run;
                        end
                        1: begin
                            send_random(rskq_pkg::ACT_DETENT);
                            sent++;
                        end
                        default: begin
                            send_random(rskq_pkg::ACT_BUTTON);
                            sent++;
                        end
                    endcase
                end
            end
            no_gaps = 1'b0;
        end

        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
